// ===== hdl/free_tree_check_core_macros.svh =====
// Assertion macros for the free tree checker.
`ifndef FREE_TREE_CHECK_CORE_MACROS_SVH
`define FREE_TREE_CHECK_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define FTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/ftc_pkg.sv =====
// Package: types and constants of the free tree checker.
package ftc_pkg;
    localparam int MAX_VERTICES = 256;
    localparam int MAX_EDGES    = 512;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int CW = VW + 1;
    localparam int TW = EW + 1;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHK_RD, ST_CHK, ST_CLR, ST_POP, ST_SCAN_RD, ST_SCAN,
        ST_PUSH, ST_VER_RD, ST_VER, ST_DONE
    } t_state;

    typedef struct packed {
        logic is_tree;
        logic input_error;
    } t_result;
endpackage

// ===== hdl/free_tree_check_core.sv =====
// Free tree checker: edge loading, connectivity walk and result register.
// Edge requests are accepted while idle. An evaluate request runs a sequencer over
// one edge memory read port: an edge range check (cut short by an error), a
// visited clearing pass over all MAX_VERTICES entries, a depth-first walk that
// scans every stored edge for each popped vertex and a visited check, then it posts
// the result. E is the stored edge count and N the vertex count. The walk only
// runs when E equals N-1. Input is stalled during evaluation. A posted result
// waits in the output register; a following evaluate holds in its last state
// until that register is free.
module free_tree_check_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // end_a[7:0], end_b[15:8]
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // is_tree[0], input_error[1], zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data      // vertex_count
);
    import ftc_pkg::*;
    `include "free_tree_check_core_macros.svh"

    t_state r_state, n_state;
    logic [8:0]  r_vcount;
    logic [TW-1:0] r_etotal, n_etotal;
    logic r_err, n_err;
    logic [TW-1:0] r_eidx, n_eidx;
    logic [CW-1:0] r_sp, n_sp;
    logic [CW-1:0] r_vidx, n_vidx;
    logic [VW-1:0] r_cur, n_cur;
    logic r_ovalid, n_ovalid;
    t_result r_res, n_res;
    t_result r_out, n_out;
    logic [CW-1:0] w_n;

    // effective vertex count
    always_comb begin
        if (r_vcount == '0) w_n = CW'(1);
        else if (r_vcount > 9'(MAX_VERTICES)) w_n = CW'(MAX_VERTICES);
        else w_n = CW'(r_vcount);
    end

    logic [VW-1:0] w_a, w_b;
    assign w_a = s_axis_tdata[VW-1:0];
    assign w_b = s_axis_tdata[8+VW-1:8];

    // memories
    logic          e_we;
    logic [EW-1:0] e_waddr, e_raddr;
    logic [2*VW-1:0] e_wdata, e_rdata;
    ftc_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata));

    logic          v_we, v_wdata, v_rdata;
    logic [VW-1:0] v_waddr, v_raddr;
    ftc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visit (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata));

    logic          s_we;
    logic [VW-1:0] s_waddr, s_raddr, s_wdata, s_rdata;
    ftc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata));

    logic [VW-1:0] w_ea, w_eb, w_nb;
    logic w_hit;
    assign w_ea = e_rdata[2*VW-1:VW];
    assign w_eb = e_rdata[VW-1:0];
    always_comb begin
        w_hit = 1'b1;
        w_nb  = w_eb;
        if (w_ea == r_cur) w_nb = w_eb;
        else if (w_eb == r_cur) w_nb = w_ea;
        else w_hit = 1'b0;
    end

    logic w_acc;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state; n_etotal = r_etotal; n_err = r_err;
        n_eidx = r_eidx; n_sp = r_sp; n_vidx = r_vidx; n_cur = r_cur;
        n_ovalid = r_ovalid; n_res = r_res; n_out = r_out;
        e_we = 1'b0; e_waddr = r_etotal[EW-1:0]; e_wdata = {w_a, w_b};
        e_raddr = r_eidx[EW-1:0];
        v_we = 1'b0; v_waddr = r_vidx[VW-1:0]; v_wdata = 1'b0;
        v_raddr = r_vidx[VW-1:0];
        s_we = 1'b0; s_waddr = r_sp[VW-1:0]; s_wdata = w_nb;
        s_raddr = r_sp[VW-1:0] - VW'(1);
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (s_axis_tuser == OP_ADD) begin
                        if (CW'(w_a) >= w_n || CW'(w_b) >= w_n ||
                            r_etotal >= TW'(MAX_EDGES)) begin
                            n_err = 1'b1;
                        end else begin
                            e_we = 1'b1;
                            n_etotal = r_etotal + TW'(1);
                        end
                    end else begin
                        n_eidx = '0;
                        n_state = ST_CHK_RD;
                    end
                end
            end
            ST_CHK_RD: begin
                if (r_err || r_eidx == r_etotal) begin
                    n_vidx = '0;
                    n_state = ST_CLR;
                end else begin
                    n_eidx = r_eidx + TW'(1);
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (CW'(w_ea) >= w_n || CW'(w_eb) >= w_n) n_err = 1'b1;
                e_raddr = r_eidx[EW-1:0];
                n_state = ST_CHK_RD;
            end
            ST_CLR: begin
                v_we = 1'b1;
                v_wdata = (r_vidx == '0);
                n_vidx = r_vidx + CW'(1);
                if (r_vidx == CW'(MAX_VERTICES - 1)) begin
                    if (!r_err && (CW'(r_etotal) + CW'(1) == w_n) &&
                        r_etotal < TW'(MAX_VERTICES)) begin
                        s_we = 1'b1; s_waddr = '0; s_wdata = '0;
                        n_sp = CW'(1);
                        n_state = ST_POP;
                    end else begin
                        n_res.is_tree = 1'b0;
                        n_res.input_error = r_err;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_POP: begin
                if (r_sp == '0) begin
                    n_vidx = '0;
                    n_state = ST_VER_RD;
                end else begin
                    n_sp = r_sp - CW'(1);
                    n_eidx = '0;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                // popped vertex is on the read port only right after the pop
                if (r_eidx == '0) n_cur = s_rdata;
                if (r_eidx == r_etotal) begin
                    n_state = ST_POP;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                v_raddr = w_nb;
                n_state = ST_PUSH;
                if (!w_hit || CW'(w_nb) >= w_n) begin
                    n_eidx = r_eidx + TW'(1);
                    n_state = ST_SCAN_RD;
                    s_raddr = r_sp[VW-1:0];
                end
            end
            ST_PUSH: begin
                if (!v_rdata && r_sp < CW'(MAX_VERTICES)) begin
                    v_we = 1'b1; v_waddr = w_nb; v_wdata = 1'b1;
                    s_we = 1'b1;
                    n_sp = r_sp + CW'(1);
                end
                n_eidx = r_eidx + TW'(1);
                e_raddr = r_eidx[EW-1:0] + EW'(1);
                s_raddr = r_sp[VW-1:0];
                n_state = ST_SCAN_RD;
            end
            ST_VER_RD: begin
                if (r_vidx == w_n) begin
                    n_res.is_tree = 1'b1;
                    n_res.input_error = 1'b0;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_VER;
                end
            end
            ST_VER: begin
                if (!v_rdata) begin
                    n_res.is_tree = 1'b0;
                    n_res.input_error = 1'b0;
                    n_state = ST_DONE;
                end else begin
                    n_vidx = r_vidx + CW'(1);
                    v_raddr = n_vidx[VW-1:0];
                    n_state = ST_VER_RD;
                end
            end
            ST_DONE: begin
                // post once the output register is free
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_out = r_res;
                    n_etotal = '0;
                    n_err = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vcount <= 9'd1;
            r_etotal <= '0;
            r_err <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_etotal <= n_etotal;
            r_err <= n_err;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) r_vcount <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eidx <= n_eidx;
        r_sp <= n_sp;
        r_vidx <= n_vidx;
        r_cur <= n_cur;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {6'd0, r_out.input_error, r_out.is_tree};

    `FTC_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, !s_axis_tready, "accepting while busy")
    `FTC_ASSERT_IMP(a_etotal_max, i_clk, i_rst_n, 1'b1, r_etotal <= TW'(MAX_EDGES), "edge count overflow")
    `FTC_ASSERT_IMP(a_res_excl, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]), "tree with error")
    `FTC_ASSERT_NEXT(a_done_out, i_clk, i_rst_n, r_state == ST_DONE && (!r_ovalid || m_axis_tready), m_axis_tvalid && r_etotal == '0, "result not posted")
endmodule

// ===== hdl/ftc_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
module ftc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
